// ===== rtl/spm_pkg.sv =====
// shared types and constants of the setpoint priority merge block
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    localparam int JOINTS_DEFAULT = 32;
    localparam int IDX_W          = 5;
    localparam int COUNT_W        = 6;
    localparam int CMP_W          = 9;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [COUNT_W-1:0] JOINT_COUNT_RESET = 6'd32;

    // register index taken from paddr[2]
    localparam logic REG_JOINT_COUNT = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [63:0]      value;
        logic [3:0]       mode;
        logic [7:0]       prio;
        logic [63:0]      stamp;
        logic [63:0]      expiry;
        logic [63:0]      now;
        logic             expired;
        logic             bad;
    } t_item;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  mode;
        logic [7:0]  prio;
        logic [63:0] stamp;
        logic [63:0] expiry;
    } t_slot;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        BK_IDLE,
        BK_DECIDE
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/spm_front.sv =====
// front end: configuration register, word acceptance and classification
`timescale 1ns / 1ps
`default_nettype none

module spm_front #(
    parameter int JOINTS = spm_pkg::JOINTS_DEFAULT
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [spm_pkg::PADDR_W-1:0]       paddr,
    input  wire  [spm_pkg::PDATA_W-1:0]       pwdata,
    output logic [spm_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  wire                               start,
    input  wire  [spm_pkg::IDX_W-1:0]         i_joint_index,
    input  wire  [63:0]                       i_ref_value,
    input  wire  [3:0]                        i_ref_mode,
    input  wire  [7:0]                        i_ref_priority,
    input  wire  [63:0]                       i_ref_time,
    input  wire  [63:0]                       i_ref_expiry,
    input  wire  [63:0]                       i_now_time,
    input  spm_pkg::t_queue_status            i_status,
    output logic                              o_push,
    output spm_pkg::t_item                    o_item
);

    logic [spm_pkg::COUNT_W-1:0] r_joint_count;
    logic                        w_wr;
    logic                        w_bad_count;
    logic                        w_bad_joints;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == spm_pkg::REG_JOINT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= spm_pkg::JOINT_COUNT_RESET;
        end else if (w_wr) begin
            r_joint_count <= pwdata[spm_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == spm_pkg::REG_JOINT_COUNT) begin
            prdata = {{(spm_pkg::PDATA_W-spm_pkg::COUNT_W){1'b0}}, r_joint_count};
        end else begin
            prdata = '0;
        end
    end

    assign w_bad_count  = {1'b0, i_joint_index} >= r_joint_count;
    assign w_bad_joints = {{(spm_pkg::CMP_W-spm_pkg::IDX_W){1'b0}}, i_joint_index}
                          >= spm_pkg::CMP_W'(JOINTS);

    assign o_push = start && !i_status.full;

    always_comb begin
        o_item.idx     = i_joint_index;
        o_item.value   = i_ref_value;
        o_item.mode    = i_ref_mode;
        o_item.prio    = i_ref_priority;
        o_item.stamp   = i_ref_time;
        o_item.expiry  = i_ref_expiry;
        o_item.now     = i_now_time;
        o_item.expired = i_now_time >= i_ref_expiry;
        o_item.bad     = w_bad_count || w_bad_joints;
    end

endmodule

`default_nettype wire

// ===== rtl/spm_queue.sv =====
// short queue of classified words between front and back
`timescale 1ns / 1ps
`default_nettype none

module spm_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  spm_pkg::t_item          i_item,
    input  wire                     i_pop,
    output spm_pkg::t_item          o_item,
    output spm_pkg::t_queue_status  o_status
);

    localparam int PW = (spm_pkg::QUEUE_DEPTH > 1) ? $clog2(spm_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(spm_pkg::QUEUE_DEPTH + 1);

    spm_pkg::t_item r_buf [spm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        if (p == PW'(spm_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_buf[r_rd_ptr];
    assign o_status.full  = r_count == CW'(spm_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

endmodule

`default_nettype wire

// ===== rtl/spm_back.sv =====
// back end: slot memory, priority decision and result register
`timescale 1ns / 1ps
`default_nettype none

module spm_back #(
    parameter int JOINTS = spm_pkg::JOINTS_DEFAULT
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  spm_pkg::t_queue_status  i_status,
    input  spm_pkg::t_item          i_item,
    output logic                    o_pop,
    output logic                    o_done,
    output logic                    o_accepted,
    output logic                    o_offer_expired,
    output logic                    o_index_error,
    output logic [63:0]             o_win_value,
    output logic [3:0]              o_win_mode,
    output logic [7:0]              o_win_priority
);

    localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    spm_pkg::t_slot       r_mem [JOINTS];
    logic [JOINTS-1:0]    r_valid;
    spm_pkg::t_slot       r_rd_slot;
    logic                 r_rd_valid;
    spm_pkg::t_item       r_item;
    logic [IW-1:0]        r_addr;
    spm_pkg::t_back_state r_state;
    spm_pkg::t_back_state n_state;

    logic [IW+spm_pkg::IDX_W-1:0] w_ext;
    logic [IW-1:0]                w_addr;
    spm_pkg::t_slot               w_stored;
    spm_pkg::t_slot               w_offer;
    logic                         w_take;
    logic                         w_wr_en;

    assign w_ext  = {{IW{1'b0}}, i_item.idx};
    assign w_addr = w_ext[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_wr_en = 1'b0;
        unique case (r_state)
            spm_pkg::BK_IDLE: begin
                if (!i_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = spm_pkg::BK_DECIDE;
                end
            end
            spm_pkg::BK_DECIDE: begin
                w_wr_en = w_take;
                n_state = spm_pkg::BK_IDLE;
            end
            default: begin
                n_state = spm_pkg::BK_IDLE;
            end
        endcase
    end

    // never-written slots read as all zero
    assign w_stored = r_rd_valid ? r_rd_slot : '0;

    always_comb begin
        w_offer.value  = r_item.value;
        w_offer.mode   = r_item.mode;
        w_offer.prio   = r_item.prio;
        w_offer.stamp  = r_item.stamp;
        w_offer.expiry = r_item.expiry;
        w_take = !r_item.bad && !r_item.expired &&
                 ((r_item.now >= w_stored.expiry) || (r_item.prio > w_stored.prio) ||
                  ((r_item.prio == w_stored.prio) && (r_item.stamp > w_stored.stamp)));
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item     <= i_item;
            r_addr     <= w_addr;
            r_rd_slot  <= r_mem[w_addr];
            r_rd_valid <= r_valid[w_addr];
        end
        if (w_wr_en) begin
            r_mem[r_addr] <= w_offer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_state == spm_pkg::BK_DECIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == spm_pkg::BK_DECIDE) begin
            o_accepted      <= w_take;
            o_offer_expired <= r_item.expired;
            o_index_error   <= r_item.bad;
            if (r_item.bad) begin
                o_win_value    <= '0;
                o_win_mode     <= '0;
                o_win_priority <= '0;
            end else if (w_take) begin
                o_win_value    <= w_offer.value;
                o_win_mode     <= w_offer.mode;
                o_win_priority <= w_offer.prio;
            end else begin
                o_win_value    <= w_stored.value;
                o_win_mode     <= w_stored.mode;
                o_win_priority <= w_stored.prio;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/setpoint_priority_merge_top.sv =====
// top level of the setpoint priority merge block
// each word is queued, popped and decided; o_done and the result are registered
// the back end finishes each word before it pops the next (read-then-update on slot memory)
// a 2-word queue lets start be taken while the back end works; busy is high when it is full
// the receiver cannot stall; each result is shown for exactly one cycle
// reset: queue and back end empty, all slots read as zero, joint_count = 32
`timescale 1ns / 1ps
`default_nettype none

module setpoint_priority_merge_top #(
    parameter int JOINTS = spm_pkg::JOINTS_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [spm_pkg::PADDR_W-1:0]  paddr,
    input  wire  [spm_pkg::PDATA_W-1:0]  pwdata,
    output logic [spm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  wire                          start,
    output logic                         busy,
    input  wire  [spm_pkg::IDX_W-1:0]    i_joint_index,
    input  wire  [63:0]                  i_ref_value,
    input  wire  [3:0]                   i_ref_mode,
    input  wire  [7:0]                   i_ref_priority,
    input  wire  [63:0]                  i_ref_time,
    input  wire  [63:0]                  i_ref_expiry,
    input  wire  [63:0]                  i_now_time,
    output logic                         o_done,
    output logic                         o_accepted,
    output logic                         o_offer_expired,
    output logic                         o_index_error,
    output logic [63:0]                  o_win_value,
    output logic [3:0]                   o_win_mode,
    output logic [7:0]                   o_win_priority
);

    spm_pkg::t_queue_status w_status;
    spm_pkg::t_item         w_in_item;
    spm_pkg::t_item         w_head;
    logic                   w_push;
    logic                   w_pop;

    assign busy = w_status.full;

    spm_front #(
        .JOINTS (JOINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .i_joint_index  (i_joint_index),
        .i_ref_value    (i_ref_value),
        .i_ref_mode     (i_ref_mode),
        .i_ref_priority (i_ref_priority),
        .i_ref_time     (i_ref_time),
        .i_ref_expiry   (i_ref_expiry),
        .i_now_time     (i_now_time),
        .i_status       (w_status),
        .o_push         (w_push),
        .o_item         (w_in_item)
    );

    spm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_in_item),
        .i_pop    (w_pop),
        .o_item   (w_head),
        .o_status (w_status)
    );

    spm_back #(
        .JOINTS (JOINTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_status        (w_status),
        .i_item          (w_head),
        .o_pop           (w_pop),
        .o_done          (o_done),
        .o_accepted      (o_accepted),
        .o_offer_expired (o_offer_expired),
        .o_index_error   (o_index_error),
        .o_win_value     (o_win_value),
        .o_win_mode      (o_win_mode),
        .o_win_priority  (o_win_priority)
    );

endmodule

`default_nettype wire

// ===== tb/spm_result_checker.sv =====
// result checker for the setpoint priority merge block: tracks winners per joint and compares
`timescale 1ns / 1ps

module spm_result_checker #(
    parameter int JOINTS = spm_pkg::JOINTS_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire                          i_pready,
    input  wire  [spm_pkg::PADDR_W-1:0]  i_paddr,
    input  wire  [spm_pkg::PDATA_W-1:0]  i_pwdata,
    input  wire                          i_start,
    input  wire                          i_busy,
    input  wire  [spm_pkg::IDX_W-1:0]    i_joint_index,
    input  wire  [63:0]                  i_ref_value,
    input  wire  [3:0]                   i_ref_mode,
    input  wire  [7:0]                   i_ref_priority,
    input  wire  [63:0]                  i_ref_time,
    input  wire  [63:0]                  i_ref_expiry,
    input  wire  [63:0]                  i_now_time,
    input  wire                          i_done,
    input  wire                          i_accepted,
    input  wire                          i_offer_expired,
    input  wire                          i_index_error,
    input  wire  [63:0]                  i_win_value,
    input  wire  [3:0]                   i_win_mode,
    input  wire  [7:0]                   i_win_priority,
    output int                           o_fail_count,
    output int                           o_pending
);
    import spm_pkg::*;

    typedef struct packed {
        logic        accepted;
        logic        offer_expired;
        logic        index_error;
        logic [63:0] value;
        logic [3:0]  mode;
        logic [7:0]  prio;
    } merge_word_t;

    t_slot              winners [JOINTS];
    logic [COUNT_W-1:0] joint_count;
    merge_word_t        merge_words_q [$];
    int                 fail_count = 0;

    function automatic merge_word_t merge_offer(
        input logic [IDX_W-1:0] idx,
        input logic [63:0]      value,
        input logic [3:0]       mode,
        input logic [7:0]       prio,
        input logic [63:0]      stamp,
        input logic [63:0]      expiry,
        input logic [63:0]      now
    );
        int          limit;
        logic        take;
        merge_word_t w;
        limit = (int'(joint_count) < JOINTS) ? int'(joint_count) : JOINTS;
        w = '0;
        w.offer_expired = (now >= expiry);
        w.index_error = (int'(idx) >= limit);
        if (!w.index_error) begin
            take = !w.offer_expired &&
                   (now >= winners[idx].expiry || prio > winners[idx].prio ||
                    (prio == winners[idx].prio && stamp > winners[idx].stamp));
            if (take) begin
                winners[idx].value = value;
                winners[idx].mode = mode;
                winners[idx].prio = prio;
                winners[idx].stamp = stamp;
                winners[idx].expiry = expiry;
            end
            w.accepted = take;
            w.value = winners[idx].value;
            w.mode = winners[idx].mode;
            w.prio = winners[idx].prio;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : check_proc
        merge_word_t want;
        if (!i_rst_n) begin
            joint_count = JOINT_COUNT_RESET;
            for (int k = 0; k < JOINTS; k++) begin
                winners[k] = '0;
            end
            merge_words_q.delete();
        end else begin
            if (i_done) begin
                if (merge_words_q.size() == 0) begin
                    report_mismatch("word with none pending", i_win_value, '0);
                end else begin
                    want = merge_words_q.pop_front();
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted", i_accepted, want.accepted);
                    if (i_offer_expired !== want.offer_expired)
                        report_mismatch("offer_expired", i_offer_expired, want.offer_expired);
                    if (i_index_error !== want.index_error)
                        report_mismatch("index_error", i_index_error, want.index_error);
                    if (i_win_value !== want.value)
                        report_mismatch("win_value", i_win_value, want.value);
                    if (i_win_mode !== want.mode)
                        report_mismatch("win_mode", i_win_mode, want.mode);
                    if (i_win_priority !== want.prio)
                        report_mismatch("win_priority", i_win_priority, want.prio);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_JOINT_COUNT) begin
                joint_count = i_pwdata[COUNT_W-1:0];
            end
            if (i_start && !i_busy) begin
                merge_words_q.push_back(merge_offer(i_joint_index, i_ref_value, i_ref_mode,
                                                    i_ref_priority, i_ref_time,
                                                    i_ref_expiry, i_now_time));
            end
        end
        o_pending = merge_words_q.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== tb/setpoint_priority_merge_top_tb.sv =====
// testbench top for the setpoint priority merge block: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module setpoint_priority_merge_top_tb;
    import spm_pkg::*;

    localparam int JOINTS = JOINTS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_OFFERS = 200;
    localparam logic [PADDR_W-1:0] JOINT_COUNT_ADDR = {REG_JOINT_COUNT, 2'b00};
    localparam logic [63:0] MAX64 = '1;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [63:0]      value;
        logic [3:0]       mode;
        logic [7:0]       prio;
        logic [63:0]      stamp;
        logic [63:0]      expiry;
        logic [63:0]      now;
    } offer_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 start = 1'b0;
    logic                 busy;
    logic [IDX_W-1:0]     i_joint_index = '0;
    logic [63:0]          i_ref_value = '0;
    logic [3:0]           i_ref_mode = '0;
    logic [7:0]           i_ref_priority = '0;
    logic [63:0]          i_ref_time = '0;
    logic [63:0]          i_ref_expiry = '0;
    logic [63:0]          i_now_time = '0;
    logic                 o_done;
    logic                 o_accepted;
    logic                 o_offer_expired;
    logic                 o_index_error;
    logic [63:0]          o_win_value;
    logic [3:0]           o_win_mode;
    logic [7:0]           o_win_priority;

    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    logic [63:0]          offer_clock = '0;

    setpoint_priority_merge_top #(
        .JOINTS(JOINTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_joint_index  (i_joint_index),
        .i_ref_value    (i_ref_value),
        .i_ref_mode     (i_ref_mode),
        .i_ref_priority (i_ref_priority),
        .i_ref_time     (i_ref_time),
        .i_ref_expiry   (i_ref_expiry),
        .i_now_time     (i_now_time),
        .o_done         (o_done),
        .o_accepted     (o_accepted),
        .o_offer_expired(o_offer_expired),
        .o_index_error  (o_index_error),
        .o_win_value    (o_win_value),
        .o_win_mode     (o_win_mode),
        .o_win_priority (o_win_priority)
    );

    spm_result_checker #(
        .JOINTS(JOINTS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_start        (start),
        .i_busy         (busy),
        .i_joint_index  (i_joint_index),
        .i_ref_value    (i_ref_value),
        .i_ref_mode     (i_ref_mode),
        .i_ref_priority (i_ref_priority),
        .i_ref_time     (i_ref_time),
        .i_ref_expiry   (i_ref_expiry),
        .i_now_time     (i_now_time),
        .i_done         (o_done),
        .i_accepted     (o_accepted),
        .i_offer_expired(o_offer_expired),
        .i_index_error  (o_index_error),
        .i_win_value    (o_win_value),
        .i_win_mode     (o_win_mode),
        .i_win_priority (o_win_priority),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic offer_t mk_offer(input logic [IDX_W-1:0] idx, input logic [63:0] value,
                                        input logic [3:0] mode, input logic [7:0] prio,
                                        input logic [63:0] stamp, input logic [63:0] expiry,
                                        input logic [63:0] now);
        offer_t o;
        o.idx = idx;
        o.value = value;
        o.mode = mode;
        o.prio = prio;
        o.stamp = stamp;
        o.expiry = expiry;
        o.now = now;
        return o;
    endfunction

    function automatic offer_t random_offer(input int limit);
        offer_t o;
        int     sel;
        int     hot;
        offer_clock = offer_clock + 64'($urandom_range(8));
        o.now = offer_clock;
        sel = $urandom_range(99);
        if (limit > 0 && $urandom_range(99) < 85) begin
            hot = (limit < 4) ? limit : 4;
            if ($urandom_range(1) == 1)
                o.idx = IDX_W'($urandom_range(hot - 1));
            else
                o.idx = IDX_W'($urandom_range(limit - 1));
        end else begin
            o.idx = IDX_W'($urandom_range(JOINTS - 1));
        end
        o.value = rand64();
        o.mode = 4'($urandom_range(15));
        o.prio = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        o.stamp = o.now - 64'($urandom_range(12));
        if (sel < 5) begin
            o.now = rand64();
            o.stamp = rand64();
            o.expiry = rand64();
        end else if (sel < 15) begin
            o.expiry = o.now - 64'($urandom_range(4));
        end else begin
            o.expiry = o.now + 64'($urandom_range(60, 1));
        end
        return o;
    endfunction

    task automatic send_offer(input offer_t o);
        start <= 1'b1;
        i_joint_index <= o.idx;
        i_ref_value <= o.value;
        i_ref_mode <= o.mode;
        i_ref_priority <= o.prio;
        i_ref_time <= o.stamp;
        i_ref_expiry <= o.expiry;
        i_now_time <= o.now;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_joint_count(input logic [COUNT_W-1:0] count);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[COUNT_W-1:0] = count;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= JOINT_COUNT_ADDR;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int counts [6];
        int limit;
        int idle_pct;
        counts = '{32, 7, 63, 1, 24, 32};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_joint_count(6'd32);

        // priority, timestamp and expiry rules on one joint
        send_offer(mk_offer(5'd0, 64'h1111, 4'd1, 8'd10, 64'd100, 64'd200, 64'd50));
        send_offer(mk_offer(5'd0, 64'h2222, 4'd2, 8'd5, 64'd150, 64'd300, 64'd60));
        send_offer(mk_offer(5'd0, 64'h3333, 4'd3, 8'd20, 64'd90, 64'd300, 64'd60));
        send_offer(mk_offer(5'd0, 64'h4444, 4'd4, 8'd20, 64'd91, 64'd300, 64'd61));
        send_offer(mk_offer(5'd0, 64'h5555, 4'd5, 8'd20, 64'd80, 64'd300, 64'd62));
        send_offer(mk_offer(5'd0, 64'h6666, 4'd6, 8'd20, 64'd91, 64'd300, 64'd63));
        send_offer(mk_offer(5'd0, 64'h7777, 4'd7, 8'd30, 64'd95, 64'd64, 64'd64));
        send_offer(mk_offer(5'd0, 64'h8888, 4'd8, 8'd1, 64'd10, 64'd400, 64'd300));
        send_offer(mk_offer(5'd0, 64'h9999, 4'd9, 8'd0, 64'd5, 64'd500, 64'd450));
        // field extremes
        send_offer(mk_offer(5'd31, MAX64, 4'hF, 8'hFF, MAX64, MAX64, MAX64 - 64'd1));
        send_offer(mk_offer(5'd31, '0, 4'd0, 8'd0, '0, MAX64, MAX64));
        send_offer(mk_offer(5'd5, '0, 4'd0, 8'd0, '0, '0, '0));
        send_offer(mk_offer(5'd6, '0, 4'd0, 8'd0, '0, 64'd1, '0));

        // single joint in use
        wait_idle();
        write_joint_count(6'd1);
        send_offer(mk_offer(5'd0, 64'hABCD, 4'd2, 8'hFF, 64'd600, 64'd1000, 64'd500));
        send_offer(mk_offer(5'd1, 64'hBCDE, 4'd3, 8'd9, 64'd600, 64'd1000, 64'd500));
        send_offer(mk_offer(5'd31, 64'hCDEF, 4'd4, 8'd9, 64'd600, 64'd0, 64'd5));

        // no joints in use
        wait_idle();
        write_joint_count(6'd0);
        send_offer(mk_offer(5'd0, 64'h1234, 4'd1, 8'd7, 64'd700, 64'd2000, 64'd600));
        send_offer(mk_offer(5'd6, 64'h2345, 4'd1, 8'd7, 64'd700, 64'd600, 64'd600));

        // count above the table size
        wait_idle();
        write_joint_count(6'd63);
        send_offer(mk_offer(5'd31, 64'h5A5A, 4'd5, 8'hFF, 64'd1, MAX64, 64'd0));
        send_offer(mk_offer(5'd17, 64'hA5A5, 4'd6, 8'd3, 64'd1, 64'd50, 64'd0));

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_joint_count(COUNT_W'(counts[p]));
            offer_clock = (p == 0) ? 64'd1000 : rand64();
            idle_pct = (p < 2) ? 35 : (p < 4) ? 55 : 0;
            limit = (counts[p] < JOINTS) ? counts[p] : JOINTS;
            for (int n = 0; n < PHASE_OFFERS; n++) begin
                send_offer(random_offer(limit));
                maybe_idle(idle_pct);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== setpoint_priority_merge_top.f =====
rtl/spm_pkg.sv
rtl/spm_front.sv
rtl/spm_queue.sv
rtl/spm_back.sv
rtl/setpoint_priority_merge_top.sv
tb/spm_result_checker.sv
tb/setpoint_priority_merge_top_tb.sv
